// ===== design/assert_macros.svh =====
// assertion macros used by the onset matcher top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define OTM_ASSERT_ALWAYS(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("otm assertion failed");

// same-cycle implication
`define OTM_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("otm assertion failed");

// next-cycle implication
`define OTM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("otm assertion failed");

`else

`define OTM_ASSERT_ALWAYS(name, clk, rst, prop)
`define OTM_ASSERT_IMPL(name, clk, rst, ante, cons)
`define OTM_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/otm_pkg.sv =====
// types and constants of the onset tolerance matcher
`timescale 1ns / 1ps

package otm_pkg;

  // table geometry
  localparam int MAX_DETECTIONS = 256;
  localparam int IDX_W          = $clog2(MAX_DETECTIONS);
  localparam int CNT_W          = $clog2(MAX_DETECTIONS + 1);

  // field widths of the beats
  localparam int CMD_W     = 2;
  localparam int POS_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 8;
  localparam int ERR_W     = 33;
  localparam int TP_W      = 9;
  localparam int FN_W      = 16;
  localparam int FP_W      = 9;

  // table word: used flag over the position
  localparam int ENTRY_W = POS_W + 1;

  localparam logic [POS_W-1:0] TOL_RESET = POS_W'(2000);
  localparam logic [FN_W-1:0]  MISS_MAX  = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_DETECTIONS);

  // commands
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MATCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MATCHED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_MISSED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_SKIPPED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd5;

  // control sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_t;

endpackage

// ===== design/otm_ram.sv =====
// single-port-write, registered-read table memory
`timescale 1ns / 1ps

module otm_ram #(
  parameter int DATA_W = 33,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/onset_tolerance_matcher_top.sv =====
// top level of the onset tolerance matcher
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Onset tolerance matcher. Store beats (command 0) append a detected onset to a
// 256-entry table; match beats (command 1) look for the nearest unused stored
// detection within match_tolerance of the truth onset (lowest index wins a tie),
// mark it used and report it with the signed error detected minus truth; a
// truth onset at position 0 is reported as skipped; clear beats (command 2)
// empty the table and the counters. Command 3 is taken and dropped without a
// result. Every result carries the running true-positive, false-negative
// (saturating) and false-positive counts. One beat is worked at a time. A
// store, clear, skipped match or match against an empty table goes straight
// to the report; any other match first scans the table, which the memory
// serves one entry per cycle through a registered read, and then reports. A
// waiting result sits in the output register and does not block acceptance
// of the next beat. match_tolerance resets to 2000; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module onset_tolerance_matcher_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write_en,
  input  logic [otm_pkg::POS_W-1:0]         cfg_write_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [otm_pkg::CMD_W-1:0]         command,
  input  logic [otm_pkg::POS_W-1:0]         onset_position,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [otm_pkg::STATUS_W-1:0]      status,
  output logic [otm_pkg::IDX_OUT_W-1:0]     matched_index,
  output logic [otm_pkg::POS_W-1:0]         matched_onset,
  output logic signed [otm_pkg::ERR_W-1:0]  onset_error,
  output logic [otm_pkg::TP_W-1:0]          true_positive_count,
  output logic [otm_pkg::FN_W-1:0]          false_negative_count,
  output logic [otm_pkg::FP_W-1:0]          false_positive_count
);

  import otm_pkg::*;

  state_t state, state_next;

  logic [POS_W-1:0]   match_tolerance;
  logic [CMD_W-1:0]   item_cmd;
  logic [POS_W-1:0]   item_pos;
  logic [CNT_W-1:0]   detection_count, detection_count_next;
  logic [CNT_W-1:0]   match_count, match_count_next;
  logic [FN_W-1:0]    miss_count, miss_count_next;

  // scan state
  logic [CNT_W-1:0]   scan_addr;
  logic               rd_pending;
  logic [IDX_W-1:0]   rd_idx;
  logic               found;
  logic [POS_W-1:0]   best_dist;
  logic [IDX_W-1:0]   best_idx;
  logic [POS_W-1:0]   best_pos;

  // memory ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  logic               accept;
  logic               slot_free;
  logic               issue;
  logic               report_go;

  logic               entry_used;
  logic [POS_W-1:0]   entry_pos;
  logic [POS_W-1:0]   entry_dist;
  logic               entry_hit;

  logic [STATUS_W-1:0] rep_status;
  logic [IDX_W-1:0]    rep_idx;
  logic [POS_W-1:0]    rep_onset;
  logic [ERR_W-1:0]    rep_err;

  // table of detections, used flag in the top bit
  otm_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_addr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // handshake and sequencing conditions
  always_comb begin
    in_stall  = (state != S_IDLE);
    accept    = in_valid && (state == S_IDLE);
    slot_free = !out_valid || !out_stall;
    issue     = (state == S_SCAN) && (scan_addr < detection_count);
    report_go = (state == S_REPORT) && slot_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_STORE, CMD_CLEAR: state_next = S_REPORT;
            CMD_MATCH: begin
              if (onset_position != '0 && detection_count != '0) begin
                state_next = S_SCAN;
              end else begin
                state_next = S_REPORT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (!issue && !rd_pending) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // distance of the entry coming back from the table
  always_comb begin
    entry_used = rd_data[ENTRY_W-1];
    entry_pos  = rd_data[POS_W-1:0];
    entry_dist = (entry_pos > item_pos) ? (entry_pos - item_pos) : (item_pos - entry_pos);
    entry_hit  = rd_pending && !entry_used &&
                 (found ? (entry_dist < best_dist) : (entry_dist <= match_tolerance));
  end

  // result and state update of the beat being reported
  always_comb begin
    rep_status           = STAT_STORED;
    rep_idx              = '0;
    rep_onset            = '0;
    rep_err              = '0;
    detection_count_next = detection_count;
    match_count_next     = match_count;
    miss_count_next      = miss_count;
    wr_en                = 1'b0;
    wr_addr              = best_idx;
    wr_data              = {1'b1, best_pos};
    case (item_cmd)
      CMD_STORE: begin
        if (detection_count >= COUNT_MAX) begin
          rep_status = STAT_FULL;
        end else begin
          rep_status           = STAT_STORED;
          wr_en                = report_go;
          wr_addr              = detection_count[IDX_W-1:0];
          wr_data              = {1'b0, item_pos};
          detection_count_next = detection_count + CNT_W'(1);
        end
      end
      CMD_MATCH: begin
        if (item_pos == '0) begin
          rep_status = STAT_SKIPPED;
        end else if (found) begin
          rep_status       = STAT_MATCHED;
          rep_idx          = best_idx;
          rep_onset        = best_pos;
          rep_err          = {1'b0, best_pos} - {1'b0, item_pos};
          wr_en            = report_go;
          match_count_next = match_count + CNT_W'(1);
        end else begin
          rep_status = STAT_MISSED;
          if (miss_count != MISS_MAX) begin
            miss_count_next = miss_count + FN_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        rep_status           = STAT_CLEARED;
        detection_count_next = '0;
        match_count_next     = '0;
        miss_count_next      = '0;
      end
      default: rep_status = STAT_STORED;
    endcase
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      detection_count <= '0;
      match_count     <= '0;
      miss_count      <= '0;
      rd_pending      <= 1'b0;
      found           <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= issue;
      if (accept) begin
        found <= 1'b0;
      end else if (entry_hit) begin
        found <= 1'b1;
      end
      if (report_go) begin
        detection_count <= detection_count_next;
        match_count     <= match_count_next;
        miss_count      <= miss_count_next;
      end
    end
  end

  // beat capture, scan address and best candidate
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd  <= command;
      item_pos  <= onset_position;
      scan_addr <= '0;
    end else if (issue) begin
      scan_addr <= scan_addr + CNT_W'(1);
    end
    rd_idx <= scan_addr[IDX_W-1:0];
    if (entry_hit) begin
      best_dist <= entry_dist;
      best_idx  <= rd_idx;
      best_pos  <= entry_pos;
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOL_RESET;
    end else if (cfg_write_en) begin
      match_tolerance <= cfg_write_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_go) begin
      status               <= rep_status;
      matched_index        <= IDX_OUT_W'(rep_idx);
      matched_onset        <= rep_onset;
      onset_error          <= rep_err;
      true_positive_count  <= TP_W'(match_count_next);
      false_negative_count <= miss_count_next;
      false_positive_count <= FP_W'(detection_count_next - match_count_next);
    end
  end

  // checks on the matcher's own bookkeeping
  `OTM_ASSERT_ALWAYS(a_match_le_count, clk, rst, match_count <= detection_count)
  `OTM_ASSERT_IMPL(a_best_in_table, clk, rst, found && state == S_REPORT, CNT_W'(best_idx) < detection_count)
  `OTM_ASSERT_IMPL(a_scan_in_range, clk, rst, state == S_SCAN, scan_addr <= detection_count)
  `OTM_ASSERT_NEXT(a_report_loads, clk, rst, report_go, out_valid && state == S_IDLE)
  `OTM_ASSERT_IMPL(a_write_not_scan, clk, rst, wr_en, state == S_REPORT && !rd_pending)

endmodule

// ===== verif/tb_onset_tolerance_matcher_top.sv =====
// self-checking testbench for the onset tolerance matcher top level
`timescale 1ns / 1ps

module tb_onset_tolerance_matcher_top;
  import otm_pkg::*;

  // command 3 is taken and dropped by the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
  } onset_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] idx;
    logic [POS_W-1:0]     pos;
    logic [ERR_W-1:0]     err;
    logic [TP_W-1:0]      tp;
    logic [FN_W-1:0]      fn;
    logic [FP_W-1:0]      fp;
  } onset_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [POS_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [POS_W-1:0] onset_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_OUT_W-1:0] matched_index;
  logic [POS_W-1:0] matched_onset;
  logic signed [ERR_W-1:0] onset_error;
  logic [TP_W-1:0] true_positive_count;
  logic [FN_W-1:0] false_negative_count;
  logic [FP_W-1:0] false_positive_count;

  onset_tolerance_matcher_top u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write_en         (cfg_write_en),
    .cfg_write_data       (cfg_write_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .command              (command),
    .onset_position       (onset_position),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .status               (status),
    .matched_index        (matched_index),
    .matched_onset        (matched_onset),
    .onset_error          (onset_error),
    .true_positive_count  (true_positive_count),
    .false_negative_count (false_negative_count),
    .false_positive_count (false_positive_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the detection table and counters
  logic [POS_W-1:0] det_pos [MAX_DETECTIONS];
  bit               det_taken [MAX_DETECTIONS];
  int unsigned      det_count = 0;
  int unsigned      hit_count = 0;
  int unsigned      miss_tally = 0;
  logic [POS_W-1:0] match_tol = TOL_RESET;

  onset_beat_t   pending_beats[$];
  onset_report_t expected_reports[$];
  onset_beat_t   cur_beat = '0;
  int            fail_count = 0;
  int            items_queued = 0;
  bit            tail_quiet = 1'b0;
  int            gap_left = 0;
  int            stall_left = 0;

  // greedy nearest-unused scoring of one accepted beat
  task automatic score_beat(input onset_beat_t b);
    onset_report_t r;
    logic [POS_W:0] best;
    int unsigned best_i;
    bit found;
    logic [POS_W-1:0] v;
    logic [POS_W-1:0] sep;
    r = '0;
    case (b.cmd)
      CMD_STORE: begin
        if (det_count >= MAX_DETECTIONS) begin
          r.status = STAT_FULL;
        end else begin
          det_pos[det_count] = b.pos;
          det_taken[det_count] = 1'b0;
          det_count++;
          r.status = STAT_STORED;
        end
      end
      CMD_MATCH: begin
        if (b.pos == '0) begin
          r.status = STAT_SKIPPED;
        end else begin
          best = {1'b0, match_tol} + 1'b1;
          best_i = 0;
          found = 1'b0;
          for (int d = 0; d < det_count; d++) begin
            if (!det_taken[d]) begin
              v = det_pos[d];
              sep = (v > b.pos) ? v - b.pos : b.pos - v;
              if (sep <= match_tol && {1'b0, sep} < best) begin
                best = {1'b0, sep};
                best_i = d;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            det_taken[best_i] = 1'b1;
            hit_count++;
            r.status = STAT_MATCHED;
            r.idx = IDX_OUT_W'(best_i);
            r.pos = det_pos[best_i];
            r.err = {1'b0, det_pos[best_i]} - {1'b0, b.pos};
          end else begin
            if (miss_tally < 65535) miss_tally++;
            r.status = STAT_MISSED;
          end
        end
      end
      CMD_CLEAR: begin
        for (int d = 0; d < MAX_DETECTIONS; d++) det_taken[d] = 1'b0;
        det_count = 0;
        hit_count = 0;
        miss_tally = 0;
        r.status = STAT_CLEARED;
      end
      default: return;
    endcase
    r.tp = TP_W'(hit_count);
    r.fn = FN_W'(miss_tally);
    r.fp = FP_W'(det_count - hit_count);
    expected_reports = {expected_reports, r};
  endtask

  // input driver: random hold-off bursts, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) score_beat(cur_beat);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!tail_quiet && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          command <= cur_beat.cmd;
          onset_position <= cur_beat.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string label, input logic [ERR_W-1:0] want,
                               input logic [ERR_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // result monitor with random stall bursts
  always @(posedge clk) begin : result_monitor
    onset_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with nothing expected: expected none, actual status %0d",
                 $time, status);
      end else begin
        want = expected_reports.pop_front();
        compare_field("status", ERR_W'(want.status), ERR_W'(status));
        compare_field("matched_index", ERR_W'(want.idx), ERR_W'(matched_index));
        compare_field("matched_onset", ERR_W'(want.pos), ERR_W'(matched_onset));
        compare_field("onset_error", want.err, onset_error);
        compare_field("true_positive_count", ERR_W'(want.tp), ERR_W'(true_positive_count));
        compare_field("false_negative_count", ERR_W'(want.fn),
                      ERR_W'(false_negative_count));
        compare_field("false_positive_count", ERR_W'(want.fp),
                      ERR_W'(false_positive_count));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!tail_quiet && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos);
    onset_beat_t b;
    b.cmd = cmd;
    b.pos = pos;
    pending_beats = {pending_beats, b};
    if (cmd != CMD_UNUSED) items_queued++;
  endtask

  // wait until every beat is taken and every result seen, then let the block go quiet
  task automatic settle_block();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [POS_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    match_tol = value;
    @(negedge clk);
  endtask

  // truth onset placed around a stored detection, tuned to the current tolerance
  function automatic logic [POS_W-1:0] truth_near(input logic [POS_W-1:0] ref_pos);
    logic [POS_W-1:0] span;
    span = (match_tol > 60000) ? 60000 : match_tol;
    case ($urandom_range(0, 15))
      0, 1: return ref_pos;
      2: return ref_pos + match_tol;
      3: return ref_pos - match_tol;
      4: return ref_pos + match_tol + 1;
      5: return ref_pos - match_tol - 1;
      13: return $urandom;
      14: return '0;
      default: return ref_pos + $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  // any command, the dropped one included
  function automatic logic [CMD_W-1:0] CMD_POS_NOISE_CMD();
    return CMD_W'($urandom_range(0, 3));
  endfunction

  // one session: usually a clear, a batch of detections, then truth onsets with some noise
  task automatic queue_session(input int n_dets, input int n_truths);
    logic [POS_W-1:0] placed[$];
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] spread;
    logic [POS_W-1:0] p;
    base = $urandom;
    spread = (match_tol > 50000) ? 100000 : match_tol * 3 + 4;
    if ($urandom_range(0, 5) != 0) push_beat(CMD_CLEAR, $urandom);
    for (int i = 0; i < n_dets; i++) begin
      if ($urandom_range(0, 19) == 0) push_beat(CMD_POS_NOISE_CMD(), $urandom);
      case ($urandom_range(0, 15))
        0, 1: p = (placed.size() > 0) ? placed[$urandom_range(0, placed.size() - 1)] : base;
        2: p = $urandom;
        default: p = base + $urandom_range(0, spread);
      endcase
      placed = {placed, p};
      push_beat(CMD_STORE, p);
    end
    for (int i = 0; i < n_truths; i++) begin
      if ($urandom_range(0, 19) == 0) push_beat(CMD_POS_NOISE_CMD(), $urandom);
      p = (placed.size() > 0) ? placed[$urandom_range(0, placed.size() - 1)] : base;
      push_beat(CMD_MATCH, truth_near(p));
    end
  endtask

  task automatic run_random(input int target);
    int n_dets;
    int n_truths;
    items_queued = 0;
    while (items_queued < target) begin
      n_dets = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      n_truths = $urandom_range(1, (n_dets > 12) ? 16 : n_dets + 4);
      queue_session(n_dets, n_truths);
    end
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, loop head, extremes, tie, tolerance edge, drop, clear
    push_beat(CMD_MATCH, 32'd500);
    push_beat(CMD_MATCH, 32'd0);
    push_beat(CMD_STORE, 32'd0);
    push_beat(CMD_STORE, 32'hFFFF_FFFF);
    push_beat(CMD_STORE, 32'd1000);
    push_beat(CMD_STORE, 32'd5000);
    push_beat(CMD_STORE, 32'd5010);
    push_beat(CMD_STORE, 32'd10000);
    push_beat(CMD_STORE, 32'd20000);
    push_beat(CMD_MATCH, 32'hFFFF_F830);
    push_beat(CMD_MATCH, 32'd5005);
    push_beat(CMD_MATCH, 32'd5005);
    push_beat(CMD_MATCH, 32'd12000);
    push_beat(CMD_MATCH, 32'd22001);
    push_beat(CMD_UNUSED, 32'd123);
    push_beat(CMD_MATCH, 32'd1);
    push_beat(CMD_MATCH, 32'd1000);
    push_beat(CMD_MATCH, 32'd1000);
    push_beat(CMD_STORE, 32'd7);
    push_beat(CMD_CLEAR, 32'hFFFF_FFFF);
    push_beat(CMD_MATCH, 32'd7);
    push_beat(CMD_STORE, 32'd300);
    push_beat(CMD_MATCH, 32'd301);
    settle_block();

    // random sessions under several tolerances, extremes first
    write_tolerance(32'd0);
    run_random(200);
    settle_block();
    write_tolerance(32'hFFFF_FFFF);
    run_random(180);
    settle_block();
    write_tolerance($urandom_range(2001, 300000));
    queue_session(MAX_DETECTIONS + 3, 12);
    run_random(160);
    settle_block();
    write_tolerance($urandom_range(1, 64));
    run_random(180);
    settle_block();

    // misses on an empty table, then a close match, no idling on either side
    tail_quiet = 1'b1;
    write_tolerance(32'd7);
    push_beat(CMD_CLEAR, 32'd0);
    for (int i = 0; i < 60; i++) push_beat(CMD_MATCH, $urandom_range(1, 32'hFFFF_FFFF));
    push_beat(CMD_STORE, 32'd42);
    push_beat(CMD_MATCH, 32'd45);
    push_beat(CMD_MATCH, 32'd9);
    settle_block();

    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("onset_tolerance_matcher_top verification clean");
    end else begin
      $display("onset_tolerance_matcher_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("onset_tolerance_matcher_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/otm_pkg.sv
design/otm_ram.sv
design/onset_tolerance_matcher_top.sv
verif/tb_onset_tolerance_matcher_top.sv
